[src/pfd_pkg.sv]
// Shared types and constants for the PCM frame downmix block.
package pfd_pkg;

  localparam int unsigned MaxChannelsDef = 8;
  localparam int unsigned SampleW        = 32;
  localparam int unsigned CfgIdxW        = 4;
  localparam int unsigned CfgDataW       = 4;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t RegSampleBytes  = cfg_idx_t'(0);
  localparam cfg_idx_t RegChannelCount = cfg_idx_t'(1);

  localparam logic [2:0] SampleBytesRst  = 3'd2;
  localparam logic [3:0] ChannelCountRst = 4'd2;
  localparam logic [2:0] MinBytes        = 3'd2;
  localparam logic [2:0] MaxBytes        = 3'd4;

  // events from the unpacker: a sample is complete, and it closes the frame
  typedef struct packed {
    logic add;
    logic last;
  } unp_ev_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    DivIdle = 3'b001,
    DivRun  = 3'b010,
    DivDone = 3'b100
  } div_state_e;

endpackage

[src/pfd_unpack.sv]
// Byte-serial sample assembly with byte and channel position counters.
module pfd_unpack import pfd_pkg::*; #(
  parameter int unsigned MaxCh = MaxChannelsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clear_i,
  input  logic               accept_i,
  input  logic [7:0]         data_byte_i,
  input  logic [2:0]         nbytes_i,
  input  logic [3:0]         nch_i,
  output logic signed [31:0] sample_o,
  output unp_ev_t            ev_o
);

  localparam int unsigned ChanPosW = (MaxCh > 1) ? $clog2(MaxCh) : 1;

  logic [31:0]         sample_q, sample_d;
  logic [1:0]          byte_pos_q, byte_pos_d;
  logic [ChanPosW-1:0] chan_pos_q, chan_pos_d;
  unp_ev_t             ev_q, ev_d;
  logic                last_byte;
  logic                last_chan;

  assign last_byte = (byte_pos_q == 2'(nbytes_i - 3'd1));
  assign last_chan = (chan_pos_q == ChanPosW'(nch_i - 4'd1));

  always_comb begin
    sample_d   = sample_q;
    byte_pos_d = byte_pos_q;
    chan_pos_d = chan_pos_q;
    ev_d       = '0;
    if (clear_i) begin
      byte_pos_d = '0;
      chan_pos_d = '0;
    end else if (accept_i) begin
      // new byte enters at the top; after the last byte the sample is left-aligned
      sample_d = {data_byte_i, (byte_pos_q == 2'd0) ? 24'd0 : sample_q[31:8]};
      if (last_byte) begin
        byte_pos_d = '0;
        ev_d.add   = 1'b1;
        ev_d.last  = last_chan;
        chan_pos_d = last_chan ? '0 : ChanPosW'(chan_pos_q + 1'b1);
      end else begin
        byte_pos_d = 2'(byte_pos_q + 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q <= '0;
      chan_pos_q <= '0;
      ev_q       <= '0;
    end else begin
      byte_pos_q <= byte_pos_d;
      chan_pos_q <= chan_pos_d;
      ev_q       <= ev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
  end

  assign sample_o = $signed(sample_q);
  assign ev_o     = ev_q;

  a_byte_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, byte_pos_q} < nbytes_i)
    else $error("byte position beyond sample width");

  a_last_is_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_q.last |-> ev_q.add)
    else $error("frame end without a finished sample");

endmodule

[src/pfd_div.sv]
// Bit-serial restoring divider: signed frame sum over channel count, toward zero.
module pfd_div import pfd_pkg::*; #(
  parameter int unsigned SumW = SampleW + $clog2(MaxChannelsDef)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [SumW-1:0] dividend_i,
  input  logic [3:0]             divisor_i,
  input  logic                   take_i,
  output div_stat_t              stat_o,
  output logic signed [31:0]     quot_o
);

  localparam int unsigned CntW = $clog2(SumW + 1);

  div_state_e      state_q, state_d;
  logic [SumW-1:0] dvd_q, dvd_d;
  logic [3:0]      rem_q, rem_d;
  logic [3:0]      dsr_q, dsr_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [4:0]      rem_sh;
  logic [4:0]      rem_sub;
  logic            ge;

  assign rem_sh  = {rem_q, dvd_q[SumW-1]};
  assign ge      = (rem_sh >= {1'b0, dsr_q});
  assign rem_sub = 5'(rem_sh - {1'b0, dsr_q});

  always_comb begin
    state_d = state_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    case (state_q)
      DivIdle: begin
        if (start_i) begin
          neg_d   = dividend_i[SumW-1];
          dvd_d   = dividend_i[SumW-1] ? SumW'(~dividend_i + 1'b1) : dividend_i;
          rem_d   = '0;
          dsr_d   = divisor_i;
          cnt_d   = '0;
          // a single channel needs no division
          state_d = (divisor_i == 4'd1) ? DivDone : DivRun;
        end
      end
      DivRun: begin
        rem_d = ge ? rem_sub[3:0] : rem_sh[3:0];
        dvd_d = {dvd_q[SumW-2:0], ge};
        cnt_d = CntW'(cnt_q + 1'b1);
        if (cnt_q == CntW'(SumW - 1)) begin
          state_d = DivDone;
        end
      end
      DivDone: begin
        if (take_i) begin
          state_d = DivIdle;
        end
      end
      default: state_d = DivIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DivIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    neg_q <= neg_d;
  end

  assign stat_o.busy = (state_q != DivIdle);
  assign stat_o.done = (state_q == DivDone);
  assign quot_o      = neg_q ? $signed(32'(~dvd_q[31:0] + 32'd1)) : $signed(dvd_q[31:0]);

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == DivIdle)
    else $error("divider started while busy");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DivDone && !take_i) |=>
      (state_q == DivDone && $stable(dvd_q) && $stable(neg_q)))
    else $error("quotient lost before it was taken");

endmodule

[src/pcm_frame_downmix.sv]
// Top level: little-endian PCM byte stream to mono Q1.31 frame average.
// One data byte is taken per cycle while in_stall_o is low. Each sample
// of 2, 3 or 4 bytes is assembled in a byte shift register, left-aligned to
// Q1.31 and added to the frame sum. After the last byte of a frame the input
// is stalled while the sum is updated and loaded into the divider, then while
// the bit-serial divider runs, one quotient bit per cycle (skipped with one
// channel), and until the quotient is handed to the output register. The
// result sits in an output register, so the next frame starts while it waits;
// a further frame result holds the divider, and with it the input, until
// that register is taken.
// Any configuration write restarts assembly at the first byte of a frame.
module pcm_frame_downmix import pfd_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = MaxChannelsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  mono_sample_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  cfg_idx_t            cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned SumW = SampleW + $clog2(MAX_CHANNELS);

  logic [2:0]             sample_bytes_q, sample_bytes_d;
  logic [3:0]             channel_count_q, channel_count_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic                   fin_q;
  logic                   out_valid_q, out_valid_d;
  logic signed [31:0]     mono_q, mono_d;

  logic                   cfg_we;
  logic                   in_accept;
  logic [2:0]             nbytes;
  logic [3:0]             nch;
  logic signed [31:0]     sample;
  unp_ev_t                ev;
  div_stat_t              div_stat;
  logic signed [31:0]     quot;
  logic                   out_load;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  always_comb begin
    sample_bytes_d  = sample_bytes_q;
    channel_count_d = channel_count_q;
    if (cfg_we) begin
      case (cfg_index_i)
        RegSampleBytes:  sample_bytes_d  = cfg_data_i[2:0];
        RegChannelCount: channel_count_d = cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sample_bytes_q < MinBytes) begin
      nbytes = MinBytes;
    end else if (sample_bytes_q > MaxBytes) begin
      nbytes = MaxBytes;
    end else begin
      nbytes = sample_bytes_q;
    end
  end

  always_comb begin
    if (channel_count_q == 4'd0) begin
      nch = 4'd1;
    end else if (32'(channel_count_q) > MAX_CHANNELS) begin
      nch = 4'(MAX_CHANNELS);
    end else begin
      nch = channel_count_q;
    end
  end

  // hold off requests from frame end until the divider has handed over its quotient
  assign in_stall_o = ev.last | fin_q | div_stat.busy;
  assign in_accept  = in_valid_i & ~in_stall_o;

  pfd_unpack #(
    .MaxCh (MAX_CHANNELS)
  ) u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_we),
    .accept_i    (in_accept),
    .data_byte_i (data_byte_i),
    .nbytes_i    (nbytes),
    .nch_i       (nch),
    .sample_o    (sample),
    .ev_o        (ev)
  );

  always_comb begin
    sum_d = sum_q;
    if (cfg_we || fin_q) begin
      sum_d = '0;
    end else if (ev.add) begin
      sum_d = SumW'(sum_q + SumW'(sample));
    end
  end

  pfd_div #(
    .SumW (SumW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (fin_q),
    .dividend_i (sum_q),
    .divisor_i  (nch),
    .take_i     (out_load),
    .stat_o     (div_stat),
    .quot_o     (quot)
  );

  assign out_load = div_stat.done & (~out_valid_q | ~out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    mono_d      = mono_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      mono_d      = quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_bytes_q  <= SampleBytesRst;
      channel_count_q <= ChannelCountRst;
      sum_q           <= '0;
      fin_q           <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      sample_bytes_q  <= sample_bytes_d;
      channel_count_q <= channel_count_d;
      sum_q           <= sum_d;
      fin_q           <= ev.last;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mono_q <= mono_d;
  end

  assign out_valid_o   = out_valid_q;
  assign mono_sample_o = mono_q;

  a_frame_end_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev.last |=> fin_q)
    else $error("frame end did not reach the divider");

  a_div_free_at_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> !div_stat.busy)
    else $error("frame finished while divider still busy");

endmodule
